[rtl/icdf_pkg.sv]
// Shared constants, widths and types for the inverse normal CDF pipeline.
// No dependencies; every rtl module imports this package.
package icdf_pkg;

  localparam int PROB_FRACTION_BITS   = 32;
  localparam int RESULT_FRACTION_BITS = 28;

  localparam int PROB_W   = 32;
  localparam int RESULT_W = 32;
  localparam int Q_W      = 32;  // folded tail value, up to 2^(PFB-1)
  localparam int E_W      = 5;   // msb index of q
  localparam int LOG_FRAC = 30;  // -log2(q) fraction bits, one squaring per bit
  localparam int NL2_W    = 36;  // -log2(q) in Q30
  localparam int U_W      = 38;  // -2 ln q in Q32
  localparam int T_W      = 27;  // t in Q24
  localparam int NUM_W    = 32;  // numerator, Q28
  localparam int DEN_W    = 34;  // denominator, Q28
  localparam int RAT_W    = 32;  // ratio, Q28

  localparam logic [27:0] LN2_Q28 = 28'd186065279;

  localparam logic [NUM_W-1:0] C0_Q28 =
    NUM_W'(((64'd2515517 << 28) + 64'd500000) / 64'd1000000);
  localparam logic [NUM_W-1:0] C1_Q28 =
    NUM_W'(((64'd802853 << 28) + 64'd500000) / 64'd1000000);
  localparam logic [NUM_W-1:0] C2_Q28 =
    NUM_W'(((64'd10328 << 28) + 64'd500000) / 64'd1000000);
  localparam logic [DEN_W-1:0] D0_Q28 =
    DEN_W'(((64'd1432788 << 28) + 64'd500000) / 64'd1000000);
  localparam logic [DEN_W-1:0] D1_Q28 =
    DEN_W'(((64'd189269 << 28) + 64'd500000) / 64'd1000000);
  localparam logic [DEN_W-1:0] D2_Q28 =
    DEN_W'(((64'd1308 << 28) + 64'd500000) / 64'd1000000);
  localparam logic [DEN_W-1:0] ONE_Q28 = DEN_W'(64'd1 << 28);

  // flags that ride along with every item
  typedef struct packed {
    logic neg;
    logic inv;
  } side_t;

endpackage

[rtl/icdf_log.sv]
// -2 ln q in Q32: mantissa normalize, one squaring stage per log2 fraction bit,
// then scaling by 2 ln2 in two stages. Depends on icdf_pkg.
module icdf_log (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [icdf_pkg::Q_W-1:0] q_i,
  input  icdf_pkg::side_t         side_i,
  output logic                    valid_o,
  output logic [icdf_pkg::U_W-1:0] u_o,
  output icdf_pkg::side_t         side_o
);
  import icdf_pkg::*;

  localparam int NS = LOG_FRAC;

  logic              vld_q [NS+1];
  logic [30:0]       m_q   [NS+1];
  logic [E_W-1:0]    e_q   [NS+1];
  logic [NS-1:0]     f_q   [NS+1];
  side_t             sd_q  [NS+1];

  logic [E_W-1:0]    msb;
  logic [Q_W+29:0]   norm;

  always_comb begin
    msb = '0;
    for (int k = 0; k < Q_W; k++) begin
      if (q_i[k]) begin
        msb = E_W'(k);
      end
    end
  end

  // q << (30 - e), or q >> 1 when e = 31
  assign norm = {q_i, 30'b0} >> msb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0]  <= norm[30:0];
      e_q[0]  <= msb;
      f_q[0]  <= '0;
      sd_q[0] <= side_i;
    end
  end

  for (genvar i = 1; i <= NS; i++) begin : g_sq
    logic [61:0] sq;
    logic [31:0] sh;
    assign sq = 62'(m_q[i-1]) * 62'(m_q[i-1]);
    assign sh = sq[61:30];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[i]  <= sh[31] ? sh[31:1] : sh[30:0];
        f_q[i]  <= sh[31] ? (f_q[i-1] | (NS'(1) << (NS - i))) : f_q[i-1];
        e_q[i]  <= e_q[i-1];
        sd_q[i] <= sd_q[i-1];
      end
    end
  end

  // -log2(q) = (PFB - e) - frac, then times 2 ln2 as two partial products
  logic [5:0]        ipart;
  logic [NL2_W-1:0]  nl2_d;
  logic [NL2_W-1:0]  nl2_q;
  logic [59:0]       plo_q;
  logic [31:0]       phi_q;
  logic [63:0]       psum;
  logic [U_W-1:0]    u_q;
  logic              vnl_q, vpp_q, vu_q;
  side_t             snl_q, spp_q, su_q;

  assign ipart = 6'(PROB_FRACTION_BITS) - {1'b0, e_q[NS]};
  assign nl2_d = {ipart, 30'b0} - {6'b0, f_q[NS]};
  assign psum  = {phi_q, 32'b0} + {4'b0, plo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vnl_q <= 1'b0;
      vpp_q <= 1'b0;
      vu_q  <= 1'b0;
    end else if (en_i) begin
      vnl_q <= vld_q[NS];
      vpp_q <= vnl_q;
      vu_q  <= vpp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nl2_q <= nl2_d;
      snl_q <= sd_q[NS];
      plo_q <= 60'(nl2_q[31:0]) * 60'(LN2_Q28);
      phi_q <= 32'(nl2_q[NL2_W-1:32]) * 32'(LN2_Q28);
      spp_q <= snl_q;
      u_q   <= psum[25 +: U_W];
      su_q  <= spp_q;
    end
  end

  assign valid_o = vu_q;
  assign u_o     = u_q;
  assign side_o  = su_q;

  mant_norm_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NS] |-> m_q[NS][30])
    else $error("log mantissa left [1,2)");

endmodule

[rtl/icdf_sqrt.sv]
// t = floor(sqrt(u * 2^16)), one result bit per stage (restoring digit method).
// Depends on icdf_pkg.
module icdf_sqrt (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [icdf_pkg::U_W-1:0] u_i,
  input  icdf_pkg::side_t          side_i,
  output logic                     valid_o,
  output logic [icdf_pkg::T_W-1:0] t_o,
  output icdf_pkg::side_t          side_o
);
  import icdf_pkg::*;

  localparam int V_W = U_W + 16;
  localparam int NS  = T_W;

  logic           vld_q [NS+1];
  logic [V_W-1:0] rem_q [NS+1];
  logic [T_W-1:0] r_q   [NS+1];
  side_t          sd_q  [NS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= {u_i, 16'b0};
      r_q[0]   <= '0;
      sd_q[0]  <= side_i;
    end
  end

  for (genvar k = 1; k <= NS; k++) begin : g_bit
    localparam int B = NS - k;
    logic [V_W:0] dd;
    logic         take;
    // (r + 2^B)^2 - r^2
    assign dd   = ((V_W+1)'(r_q[k-1]) << (B + 1)) | ((V_W+1)'(1) << (2 * B));
    assign take = {1'b0, rem_q[k-1]} >= dd;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? (rem_q[k-1] - dd[V_W-1:0]) : rem_q[k-1];
        r_q[k]   <= take ? (r_q[k-1] | (T_W'(1) << B)) : r_q[k-1];
        sd_q[k]  <= sd_q[k-1];
      end
    end
  end

  assign valid_o = vld_q[NS];
  assign t_o     = r_q[NS];
  assign side_o  = sd_q[NS];

  sqrt_rem_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NS] |-> (rem_q[NS] <= V_W'({r_q[NS], 1'b0})))
    else $error("sqrt remainder exceeds 2t");

endmodule

[rtl/icdf_poly.sv]
// Horner evaluation of numerator and denominator polynomials in t, Q28.
// Depends on icdf_pkg.
module icdf_poly (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [icdf_pkg::T_W-1:0]   t_i,
  input  icdf_pkg::side_t            side_i,
  output logic                       valid_o,
  output logic [icdf_pkg::T_W-1:0]   t_o,
  output logic [icdf_pkg::NUM_W-1:0] num_o,
  output logic [icdf_pkg::DEN_W-1:0] den_o,
  output icdf_pkg::side_t            side_o
);
  import icdf_pkg::*;

  localparam int PN_W = NUM_W + T_W;
  localparam int PD_W = DEN_W + T_W;

  logic             v1_q, v2_q, v3_q;
  logic [T_W-1:0]   t1_q, t2_q, t3_q;
  logic [NUM_W-1:0] n1_q, n2_q, n3_q;
  logic [DEN_W-1:0] d1_q, d2_q, d3_q;
  side_t            s1_q, s2_q, s3_q;

  logic [PN_W-1:0]  pn1, pn2;
  logic [PD_W-1:0]  pd1, pd2, pd3;

  assign pn1 = PN_W'(C2_Q28) * PN_W'(t_i);
  assign pd1 = PD_W'(D2_Q28) * PD_W'(t_i);
  assign pn2 = PN_W'(n1_q) * PN_W'(t1_q);
  assign pd2 = PD_W'(d1_q) * PD_W'(t1_q);
  assign pd3 = PD_W'(d2_q) * PD_W'(t2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n1_q <= NUM_W'(pn1 >> 24) + C1_Q28;
      d1_q <= DEN_W'(pd1 >> 24) + D1_Q28;
      t1_q <= t_i;
      s1_q <= side_i;
      n2_q <= NUM_W'(pn2 >> 24) + C0_Q28;
      d2_q <= DEN_W'(pd2 >> 24) + D0_Q28;
      t2_q <= t1_q;
      s2_q <= s1_q;
      n3_q <= n2_q;
      d3_q <= DEN_W'(pd3 >> 24) + ONE_Q28;
      t3_q <= t2_q;
      s3_q <= s2_q;
    end
  end

  assign valid_o = v3_q;
  assign t_o     = t3_q;
  assign num_o   = n3_q;
  assign den_o   = d3_q;
  assign side_o  = s3_q;

endmodule

[rtl/icdf_div.sv]
// ratio = floor(num * 2^28 / den), restoring division, one quotient bit per stage.
// Depends on icdf_pkg.
module icdf_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [icdf_pkg::T_W-1:0]   t_i,
  input  logic [icdf_pkg::NUM_W-1:0] num_i,
  input  logic [icdf_pkg::DEN_W-1:0] den_i,
  input  icdf_pkg::side_t            side_i,
  output logic                       valid_o,
  output logic [icdf_pkg::T_W-1:0]   t_o,
  output logic [icdf_pkg::RAT_W-1:0] ratio_o,
  output icdf_pkg::side_t            side_o
);
  import icdf_pkg::*;

  localparam int NS = RAT_W;

  logic             vld_q [NS+1];
  logic [DEN_W-1:0] rem_q [NS+1];
  logic [NS-1:0]    low_q [NS+1];
  logic [NS-1:0]    quo_q [NS+1];
  logic [DEN_W-1:0] den_q [NS+1];
  logic [T_W-1:0]   t_q   [NS+1];
  side_t            sd_q  [NS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  // dividend num << 28: top bits seed the remainder, low 32 bits shift in
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= DEN_W'(num_i >> 4);
      low_q[0] <= {num_i[3:0], 28'b0};
      quo_q[0] <= '0;
      den_q[0] <= den_i;
      t_q[0]   <= t_i;
      sd_q[0]  <= side_i;
    end
  end

  for (genvar j = 1; j <= NS; j++) begin : g_bit
    logic [DEN_W:0] sh;
    logic [DEN_W:0] diff;
    logic           take;
    assign sh   = {rem_q[j-1], low_q[j-1][NS-1]};
    assign diff = sh - {1'b0, den_q[j-1]};
    assign take = sh >= {1'b0, den_q[j-1]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= take ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
        low_q[j] <= low_q[j-1] << 1;
        quo_q[j] <= {quo_q[j-1][NS-2:0], take};
        den_q[j] <= den_q[j-1];
        t_q[j]   <= t_q[j-1];
        sd_q[j]  <= sd_q[j-1];
      end
    end
  end

  assign valid_o = vld_q[NS];
  assign t_o     = t_q[NS];
  assign ratio_o = quo_q[NS];
  assign side_o  = sd_q[NS];

  div_rem_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NS] |-> (rem_q[NS] < den_q[NS]))
    else $error("division remainder not below divisor");

endmodule

[rtl/inverse_normal_cdf_unit.sv]
// Inverse normal CDF (A&S 26.2.23) top level: fold, log, sqrt, poly, divide, output.
// Depends on icdf_pkg, icdf_log, icdf_sqrt, icdf_poly, icdf_div.
//
//   port group  dir  tdata                 tuser
//   s_axis      in   [31:0] prob           -
//   m_axis      out  [31:0] quantile Q4.28 [0] invalid
//
// One item per cycle while m_axis does not stall; the stages run fold, log, sqrt, poly,
// divide, output, and the depth comes mostly from the per-bit log squaring, sqrt and divide stages.
// Reset clears only the valid bits; payload registers are not reset.
// The whole pipeline advances whenever the output register is empty or taken,
// so a stall at m_axis freezes every stage and s_axis_tready_o drops with it.
module inverse_normal_cdf_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [icdf_pkg::PROB_W-1:0]       s_axis_tdata_i,   // [31:0] prob
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [icdf_pkg::RESULT_W-1:0]     m_axis_tdata_o,   // [31:0] quantile
  output logic                              m_axis_tuser_o    // [0] invalid
);
  import icdf_pkg::*;

  localparam int SHIFT = RESULT_FRACTION_BITS - 28;
  localparam int LSH   = (SHIFT >= 0) ? SHIFT : 0;
  localparam int RSH   = (SHIFT < 0) ? -SHIFT : 1;

  logic en;

  // fold to tail value
  logic [PROB_W:0]  full, half;
  logic             inv_d, neg_d;
  logic [Q_W-1:0]   q_d;
  logic             vf_q;
  logic [Q_W-1:0]   qf_q;
  side_t            sf_q;

  assign full  = (PROB_W+1)'(1) << PROB_FRACTION_BITS;
  assign half  = full >> 1;
  assign inv_d = (s_axis_tdata_i == '0) || ({1'b0, s_axis_tdata_i} >= full);
  assign neg_d = {1'b0, s_axis_tdata_i} < half;

  always_comb begin
    if (inv_d) begin
      q_d = Q_W'(1);
    end else if (neg_d) begin
      q_d = s_axis_tdata_i;
    end else begin
      q_d = Q_W'(full - {1'b0, s_axis_tdata_i});
    end
  end

  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else if (en) begin
      vf_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      qf_q     <= q_d;
      sf_q.neg <= neg_d;
      sf_q.inv <= inv_d;
    end
  end

  logic             vl, vs, vp, vd;
  logic [U_W-1:0]   u;
  logic [T_W-1:0]   ts, tp, td;
  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den;
  logic [RAT_W-1:0] ratio;
  side_t            sl, ss, sp, sd;

  icdf_log u_log (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(vf_q), .q_i(qf_q), .side_i(sf_q),
    .valid_o(vl), .u_o(u), .side_o(sl)
  );

  icdf_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(vl), .u_i(u), .side_i(sl),
    .valid_o(vs), .t_o(ts), .side_o(ss)
  );

  icdf_poly u_poly (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(vs), .t_i(ts), .side_i(ss),
    .valid_o(vp), .t_o(tp), .num_o(num), .den_o(den), .side_o(sp)
  );

  icdf_div u_div (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(vp), .t_i(tp), .num_i(num), .den_i(den), .side_i(sp),
    .valid_o(vd), .t_o(td), .ratio_o(ratio), .side_o(sd)
  );

  // x = t - ratio, sign fold, rescale, saturate
  logic [32:0]         x;
  logic                xneg, negf;
  logic [32:0]         mag;
  logic [63:0]         mag_s, limit, sat;
  logic [RESULT_W-1:0] res_d;

  assign x    = {2'b0, td, 4'b0} - {1'b0, ratio};
  assign xneg = x[32];
  assign mag  = xneg ? (33'd0 - x) : x;
  assign negf = sd.neg ^ xneg;

  if (SHIFT >= 0) begin : g_lsh
    assign mag_s = 64'(mag) << LSH;
  end else begin : g_rsh
    assign mag_s = (64'(mag) + (64'd1 << (RSH - 1))) >> RSH;
  end

  assign limit = negf ? (64'd1 << 31) : ((64'd1 << 31) - 64'd1);
  assign sat   = (mag_s > limit) ? limit : mag_s;

  always_comb begin
    if (sd.inv) begin
      res_d = '0;
    end else if (negf) begin
      res_d = RESULT_W'(32'd0 - sat[31:0]);
    end else begin
      res_d = RESULT_W'(sat[31:0]);
    end
  end

  logic                vo_q;
  logic [RESULT_W-1:0] res_q;
  logic                inv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en) begin
      vo_q <= vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
      inv_q <= sd.inv;
    end
  end

  assign m_axis_tvalid_o = vo_q;
  assign m_axis_tdata_o  = res_q;
  assign m_axis_tuser_o  = inv_q;

  inv_zero_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && inv_q) |-> (res_q == '0))
    else $error("invalid item with nonzero quantile");

endmodule
